/* design/dlc_pkg.sv */
// Shared types and constants for the door lock controller.
// Phase and status codes, config register map, result record.
// No dependencies.
package dlc_pkg;

	localparam int CODE_W         = 40;
	localparam int CODE_BYTES_DEF = 5;
	localparam int TICK_W         = 16;
	localparam int MISS_W         = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam logic [MISS_W-1:0] MISS_MAX = 3'd7;

	// request modes
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_NEWCODE = 2'd1;
	localparam logic [1:0] MODE_ACCESS  = 2'd2;

	// request actions
	localparam logic ACT_OPEN   = 1'b0;
	localparam logic ACT_CHANGE = 1'b1;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPT = 3'd4;

	// config reset values
	localparam logic [TICK_W-1:0] HOLD_START_RST  = 16'd458;
	localparam logic [TICK_W-1:0] CLOSE_START_RST = 16'd550;
	localparam logic [TICK_W-1:0] CLOSE_END_RST   = 16'd1008;
	localparam logic [TICK_W-1:0] LOCKOUT_LEN_RST = 16'd1832;
	localparam logic [MISS_W-1:0] MAX_ATTEMPT_RST = 3'd3;

	typedef enum logic [2:0] {
		PH_SETUP   = 3'd0,
		PH_IDLE    = 3'd1,
		PH_OPEN    = 3'd2,
		PH_HOLD    = 3'd3,
		PH_CLOSE   = 3'd4,
		PH_LOCKOUT = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_TICK    = 3'd0,
		ST_MATCH   = 3'd1,
		ST_MISS    = 3'd2,
		ST_LOCK    = 3'd3,
		ST_IGNORED = 3'd4,
		ST_STORED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MOTOR_OFF  = 2'd0,
		MOTOR_CW   = 2'd1,
		MOTOR_CCW  = 2'd2
	} motor_t;

	typedef struct packed {
		logic [TICK_W-1:0] hold_start_tick;
		logic [TICK_W-1:0] close_start_tick;
		logic [TICK_W-1:0] close_end_tick;
		logic [TICK_W-1:0] lockout_length;
		logic [MISS_W-1:0] max_attempts;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [CODE_W-1:0] entered_code;
		logic [CODE_W-1:0] repeat_code;
		logic              action;
	} req_t;

	typedef struct packed {
		status_t           status;
		motor_t            motor;
		logic              buzzer;
		phase_t            phase;
		logic [MISS_W-1:0] misses;
	} result_t;

endpackage

/* design/dlc_cfg_regs.sv */
// Configuration register file for the door lock controller.
// Uses dlc_pkg for the register map and reset values.
module dlc_cfg_regs
	import dlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_start_tick  <= HOLD_START_RST;
			cfg_q.close_start_tick <= CLOSE_START_RST;
			cfg_q.close_end_tick   <= CLOSE_END_RST;
			cfg_q.lockout_length   <= LOCKOUT_LEN_RST;
			cfg_q.max_attempts     <= MAX_ATTEMPT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_HOLD_START:  cfg_q.hold_start_tick  <= wr_data[TICK_W-1:0];
				REG_CLOSE_START: cfg_q.close_start_tick <= wr_data[TICK_W-1:0];
				REG_CLOSE_END:   cfg_q.close_end_tick   <= wr_data[TICK_W-1:0];
				REG_LOCKOUT_LEN: cfg_q.lockout_length   <= wr_data[TICK_W-1:0];
				REG_MAX_ATTEMPT: cfg_q.max_attempts     <= wr_data[MISS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/dlc_core.sv */
// Lock state machine: phase, tick and miss counters, stored code.
// Computes the result of one request and commits state on advance.
// Uses dlc_pkg types and codes.
module dlc_core
	import dlc_pkg::*;
#(
	parameter int CODE_BYTES = CODE_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  req_t    req,
	input  cfg_t    cfg,
	output result_t result
);

	// only the low CODE_BYTES bytes of a code take part
	localparam int CODE_BITS = (CODE_BYTES * 8 > CODE_W) ? CODE_W : CODE_BYTES * 8;

	phase_t                phase_q, phase_d;
	logic [TICK_W-1:0]     tick_q, tick_d, tick_inc;
	logic [MISS_W-1:0]     miss_q, miss_d, miss_inc;
	logic [CODE_BITS-1:0]  code_q;
	logic [CODE_BITS-1:0]  code_a, code_b;
	logic                  code_we;
	status_t               status_d;
	motor_t                motor_d;

	assign code_a = req.entered_code[CODE_BITS-1:0];
	assign code_b = req.repeat_code[CODE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETUP;
			tick_q  <= '0;
			miss_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			miss_q  <= miss_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && code_we)
			code_q <= code_b;
	end

	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		miss_d   = miss_q;
		status_d = ST_IGNORED;
		code_we  = 1'b0;
		tick_inc = tick_q + 16'd1;
		miss_inc = (miss_q == MISS_MAX) ? miss_q : miss_q + 3'd1;

		case (req.mode)
			MODE_TICK: begin
				status_d = ST_TICK;
				case (phase_q)
					PH_OPEN: begin
						tick_d = tick_inc;
						if (tick_inc == cfg.hold_start_tick)
							phase_d = PH_HOLD;
					end
					PH_HOLD: begin
						tick_d = tick_inc;
						if (tick_inc == cfg.close_start_tick)
							phase_d = PH_CLOSE;
					end
					PH_CLOSE: begin
						tick_d = tick_inc;
						if (tick_inc == cfg.close_end_tick) begin
							phase_d = PH_IDLE;
							tick_d  = '0;
						end
					end
					PH_LOCKOUT: begin
						tick_d = tick_inc;
						if (tick_inc >= cfg.lockout_length) begin
							phase_d = PH_IDLE;
							tick_d  = '0;
							miss_d  = '0;
						end
					end
					default: ;
				endcase
			end
			MODE_NEWCODE: begin
				if (phase_q == PH_SETUP) begin
					if (code_a == code_b) begin
						code_we  = 1'b1;
						phase_d  = PH_IDLE;
						status_d = ST_STORED;
					end else begin
						status_d = ST_MISS;
					end
				end
			end
			MODE_ACCESS: begin
				if (phase_q == PH_IDLE) begin
					if (code_a == code_q) begin
						miss_d   = '0;
						status_d = ST_MATCH;
						if (req.action == ACT_OPEN) begin
							phase_d = PH_OPEN;
							tick_d  = '0;
						end else begin
							phase_d = PH_SETUP;
						end
					end else begin
						miss_d = miss_inc;
						if (miss_inc >= cfg.max_attempts) begin
							phase_d  = PH_LOCKOUT;
							tick_d   = '0;
							status_d = ST_LOCK;
						end else begin
							status_d = ST_MISS;
						end
					end
				end
			end
			default: ;
		endcase

		case (phase_d)
			PH_OPEN:  motor_d = MOTOR_CW;
			PH_CLOSE: motor_d = MOTOR_CCW;
			default:  motor_d = MOTOR_OFF;
		endcase

		result.status = status_d;
		result.motor  = motor_d;
		result.buzzer = (phase_d == PH_LOCKOUT);
		result.phase  = phase_d;
		result.misses = miss_d;
	end

endmodule

/* design/door_lock_controller_unit.sv */
// Door lock controller: input register, lock state machine, result register.
// Depends on dlc_pkg, dlc_cfg_regs and dlc_core.
//
// Usage:
//   Requests come in on in_valid/in_ready with mode, entered_code, repeat_code
//   and action. Each request yields exactly one result on out_valid/out_ready
//   with status, motor_drive, buzzer, phase and failed_attempts, all showing
//   the lock state after that request.
//   Config registers are written on cfg_valid/cfg_ready (cfg_ready is always
//   high) with cfg_index 0..4 and cfg_data; write them only while no request
//   is in flight.
//   Path: a taken request sits in the input register and is evaluated into
//   the result register when it advances, where out_valid rises. Throughput:
//   one request per cycle while out_ready is high; the lock state updates in
//   the same cycle a request moves from the input register into the result
//   register.
//   Stall: if out_ready is low with a result pending, the input register still
//   takes one more request, then in_ready drops until the result is taken.
//   Reset: the lock starts in code setup with zero counters and the config
//   registers at their defaults; no code is stored until a matching pair.
module door_lock_controller_unit
	import dlc_pkg::*;
#(
	parameter int CODE_BYTES = CODE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [CODE_W-1:0]     entered_code,
	input  logic [CODE_W-1:0]     repeat_code,
	input  logic                  action,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [1:0]            motor_drive,
	output logic                  buzzer,
	output logic [2:0]            phase,
	output logic [MISS_W-1:0]     failed_attempts,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	req_t    req_s1;
	logic    valid_s1;
	logic    advance;
	result_t res_d, res_q;
	logic    out_valid_q;

	assign cfg_ready = 1'b1;

	dlc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// request moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.mode         <= mode;
			req_s1.entered_code <= entered_code;
			req_s1.repeat_code  <= repeat_code;
			req_s1.action       <= action;
		end
	end

	dlc_core #(
		.CODE_BYTES (CODE_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_d;
	end

	assign out_valid       = out_valid_q;
	assign status          = res_q.status;
	assign motor_drive     = res_q.motor;
	assign buzzer          = res_q.buzzer;
	assign phase           = res_q.phase;
	assign failed_attempts = res_q.misses;

endmodule
